[design/dbi2c_pkg.sv]
// ----------------------------------------------------------------------------
// dbi2c_pkg
// Types and codes shared by the dual-bus I2C bit master.
// ----------------------------------------------------------------------------
package dbi2c_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WAIT  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_HIGH = 4'd1,
    PH_ST_LOW  = 4'd2,
    PH_SP_LOW  = 4'd3,
    PH_SP_HIGH = 4'd4,
    PH_TX_HIGH = 4'd5,
    PH_TX_LOW  = 4'd6,
    PH_RX_LOW  = 4'd7,
    PH_RX_HIGH = 4'd8,
    PH_AK_LOW  = 4'd9,
    PH_AK_HIGH = 4'd10,
    PH_WA_REL  = 4'd11,
    PH_WA_HIGH = 4'd12,
    PH_WA_POLL = 4'd13
  } phase_t;

  // pin slots within one bus
  localparam logic [1:0] PIN_SCL = 2'd0;
  localparam logic [1:0] PIN_SDA = 2'd1;
  localparam logic [1:0] PIN_OE  = 2'd2;

  localparam logic [5:0] PINS_RESET = 6'h3F;

  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    phase_t     phase;
    logic       active_bus;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [7:0] timeout_count;
    logic [5:0] pins;        // {oe_b, sda_b, scl_b, oe_a, sda_a, scl_a}
    logic [7:0] last_rx;
    logic       fail_flag;
    logic       ack_choice;
  } seq_state_t;

endpackage

[design/dbi2c_step.sv]
// ----------------------------------------------------------------------------
// dbi2c_step
// One tick of the bus sequencer: next state, timer and done from the
// current state, one input item and the configuration.
// ----------------------------------------------------------------------------
module dbi2c_step #(
  parameter int TIMER_BITS = 16
) (
  input  dbi2c_pkg::seq_state_t  st,
  input  logic [TIMER_BITS-1:0]  delay_timer,
  input  logic [2:0]             command,
  input  logic                   bus_select,
  input  logic [7:0]             tx_byte,
  input  logic                   send_ack,
  input  logic                   sda_in_a,
  input  logic                   sda_in_b,
  input  logic [15:0]            half_period_ticks,
  input  logic [7:0]             ack_timeout,
  output dbi2c_pkg::seq_state_t  st_next,
  output logic [TIMER_BITS-1:0]  delay_timer_next,
  output logic                   done
);
  import dbi2c_pkg::*;

  localparam int LW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [LW-1:0] TMAX = LW'({TIMER_BITS{1'b1}});

  function automatic logic [5:0] put_pin(logic [5:0] p, logic bus, logic [1:0] which,
                                         logic lvl);
    logic [5:0] r;
    logic [2:0] idx;
    r = p;
    idx = {1'b0, which} + (bus ? 3'd3 : 3'd0);
    r[idx] = lvl;
    return r;
  endfunction

  logic [LW-1:0]          hp_ext;
  logic [LW-1:0]          load_ext;
  logic [TIMER_BITS-1:0]  load_val;
  logic                   cmd_ok;
  logic                   timed;
  logic                   expired;
  logic                   sda_now;
  logic                   poll_fail;
  logic [3:0]             bc_inc;
  logic                   bus;
  phase_t                 phase_next;

  assign hp_ext   = LW'(half_period_ticks);
  assign load_ext = (hp_ext == '0) ? LW'(1) : ((hp_ext > TMAX) ? TMAX : hp_ext);
  assign load_val = load_ext[TIMER_BITS-1:0];

  assign cmd_ok    = (command >= CMD_START) && (command <= CMD_WAIT);
  assign timed     = (st.phase != PH_IDLE) && (st.phase != PH_WA_POLL);
  assign expired   = (delay_timer <= TIMER_BITS'(1));
  assign sda_now   = st.active_bus ? sda_in_b : sda_in_a;
  assign poll_fail = (st.timeout_count >= ack_timeout);
  assign bc_inc    = st.bit_count + 4'd1;
  assign bus       = (st.phase == PH_IDLE && cmd_ok) ? bus_select : st.active_bus;

  // next phase
  always_comb begin
    phase_next = st.phase;
    case (st.phase)
      PH_IDLE: begin
        if (cmd_ok) begin
          case (command)
            CMD_START: phase_next = PH_ST_HIGH;
            CMD_STOP:  phase_next = PH_SP_LOW;
            CMD_SEND:  phase_next = PH_TX_HIGH;
            CMD_READ:  phase_next = PH_RX_LOW;
            default:   phase_next = PH_WA_REL;
          endcase
        end
      end
      PH_WA_POLL: begin
        if (!sda_now)       phase_next = PH_IDLE;
        else if (poll_fail) phase_next = PH_SP_LOW;
      end
      default: begin
        if (expired) begin
          case (st.phase)
            PH_ST_HIGH: phase_next = PH_ST_LOW;
            PH_ST_LOW:  phase_next = PH_IDLE;
            PH_SP_LOW:  phase_next = PH_SP_HIGH;
            PH_SP_HIGH: phase_next = PH_IDLE;
            PH_TX_HIGH: phase_next = PH_TX_LOW;
            PH_TX_LOW:  phase_next = bc_inc[3] ? PH_IDLE : PH_TX_HIGH;
            PH_RX_LOW:  phase_next = PH_RX_HIGH;
            PH_RX_HIGH: phase_next = bc_inc[3] ? PH_AK_LOW : PH_RX_LOW;
            PH_AK_LOW:  phase_next = PH_AK_HIGH;
            PH_AK_HIGH: phase_next = PH_IDLE;
            PH_WA_REL:  phase_next = PH_WA_HIGH;
            PH_WA_HIGH: phase_next = PH_WA_POLL;
            default:    phase_next = PH_IDLE;
          endcase
        end
      end
    endcase
  end

  // datapath and pin levels
  always_comb begin
    st_next = st;
    st_next.phase = phase_next;
    st_next.active_bus = bus;

    if (phase_next != st.phase && phase_next != PH_IDLE && phase_next != PH_WA_POLL)
      delay_timer_next = load_val;
    else if (timed && !expired)
      delay_timer_next = delay_timer - TIMER_BITS'(1);
    else
      delay_timer_next = delay_timer;

    case (st.phase)
      PH_IDLE: begin
        if (cmd_ok) begin
          st_next.bit_count = 4'd0;
          case (command)
            CMD_START: begin
              st_next.pins = put_pin(st_next.pins, bus, PIN_OE, 1'b1);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, 1'b1);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b1);
            end
            CMD_STOP: begin
              st_next.pins = put_pin(st_next.pins, bus, PIN_OE, 1'b1);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, 1'b0);
            end
            CMD_SEND: begin
              st_next.shift_reg = tx_byte;
              st_next.pins = put_pin(st_next.pins, bus, PIN_OE, 1'b1);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, tx_byte[7]);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b1);
            end
            CMD_READ: begin
              st_next.shift_reg = 8'd0;
              st_next.ack_choice = send_ack;
              st_next.pins = put_pin(st_next.pins, bus, PIN_OE, 1'b0);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
            end
            default: begin
              st_next.fail_flag = 1'b0;
              st_next.pins = put_pin(st_next.pins, bus, PIN_OE, 1'b0);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, 1'b1);
            end
          endcase
        end
      end
      PH_WA_POLL: begin
        if (!sda_now) begin
          st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
        end else if (poll_fail) begin
          // timed out: flag it and release the bus with a STOP
          st_next.fail_flag = 1'b1;
          st_next.pins = put_pin(st_next.pins, bus, PIN_OE, 1'b1);
          st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
          st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, 1'b0);
        end else begin
          st_next.timeout_count = st.timeout_count + 8'd1;
        end
      end
      default: begin
        if (expired) begin
          case (st.phase)
            PH_ST_HIGH: st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, 1'b0);
            PH_ST_LOW:  st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
            PH_SP_LOW: begin
              st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b1);
              st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, 1'b1);
            end
            PH_TX_HIGH: st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
            PH_TX_LOW: begin
              st_next.bit_count = bc_inc;
              st_next.shift_reg = {st.shift_reg[6:0], 1'b0};
              if (!bc_inc[3]) begin
                st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, st.shift_reg[6]);
                st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b1);
              end
            end
            PH_RX_LOW:  st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b1);
            PH_RX_HIGH: begin
              st_next.shift_reg = {st.shift_reg[6:0], sda_now};
              st_next.bit_count = bc_inc;
              st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
              if (bc_inc[3]) begin
                st_next.last_rx = {st.shift_reg[6:0], sda_now};
                st_next.pins = put_pin(st_next.pins, bus, PIN_OE, 1'b1);
                st_next.pins = put_pin(st_next.pins, bus, PIN_SDA, !st.ack_choice);
              end
            end
            PH_AK_LOW:  st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b1);
            PH_AK_HIGH: st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b0);
            PH_WA_REL:  st_next.pins = put_pin(st_next.pins, bus, PIN_SCL, 1'b1);
            PH_WA_HIGH: st_next.timeout_count = 8'd0;
            default: ;
          endcase
        end
      end
    endcase
  end

  assign done = (st.phase != PH_IDLE) && (phase_next == PH_IDLE);

endmodule

[design/dual_bus_i2c_bit_master.sv]
// ----------------------------------------------------------------------------
// dual_bus_i2c_bit_master
// Bit-level I2C master sequencer for two buses; one input transfer per tick.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------
//  in      | in_valid / in_stall       | command, bus_select, tx_byte, send_ack,
//          |                           | sda_in_a, sda_in_b
//  out     | out_valid / out_stall     | scl_a..sda_b_drive_enable, busy_res,
//          |                           | done_res, rx_byte, ack_failed
//  cfg     | cfg_write_enable          | cfg_index, cfg_write_data
//
// An input transfer reaches the result through the input register, then the
// sequencer step that updates state and loads the result register.
// One item per cycle is sustained while out_stall is low; the step is a single pass through dbi2c_step.
// A stalled result holds the step; the input register then fills and in_stall rises.
// Synchronous reset restores the sequencer's pin state to all high and driven and the default config.
// ----------------------------------------------------------------------------
module dual_bus_i2c_bit_master #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic        bus_select,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic        sda_in_a,
  input  logic        sda_in_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_a,
  output logic        sda_a,
  output logic        sda_a_drive_enable,
  output logic        scl_b,
  output logic        sda_b,
  output logic        sda_b_drive_enable,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic        ack_failed,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_write_data
);
  import dbi2c_pkg::*;

  logic [15:0]           half_period_ticks;
  logic [7:0]            ack_timeout;

  logic                  in_valid_r;
  logic [2:0]            command_r;
  logic                  bus_select_r;
  logic [7:0]            tx_byte_r;
  logic                  send_ack_r;
  logic                  sda_in_a_r;
  logic                  sda_in_b_r;

  seq_state_t            st;
  seq_state_t            st_next;
  logic [TIMER_BITS-1:0] delay_timer;
  logic [TIMER_BITS-1:0] delay_timer_next;
  logic                  step_done;
  logic                  move;
  logic                  in_take;

  assign move     = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_period_ticks <= cfg_write_data;
        REG_ACK_TIMEOUT: ack_timeout <= cfg_write_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      command_r <= command;
      bus_select_r <= bus_select;
      tx_byte_r <= tx_byte;
      send_ack_r <= send_ack;
      sda_in_a_r <= sda_in_a;
      sda_in_b_r <= sda_in_b;
    end
  end

  dbi2c_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .st                (st),
    .delay_timer       (delay_timer),
    .command           (command_r),
    .bus_select        (bus_select_r),
    .tx_byte           (tx_byte_r),
    .send_ack          (send_ack_r),
    .sda_in_a          (sda_in_a_r),
    .sda_in_b          (sda_in_b_r),
    .half_period_ticks (half_period_ticks),
    .ack_timeout       (ack_timeout),
    .st_next           (st_next),
    .delay_timer_next  (delay_timer_next),
    .done              (step_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_IDLE;
      st.active_bus <= 1'b0;
      st.bit_count <= 4'd0;
      st.shift_reg <= 8'd0;
      st.timeout_count <= 8'd0;
      st.pins <= PINS_RESET;
      st.last_rx <= 8'd0;
      st.fail_flag <= 1'b0;
      st.ack_choice <= 1'b0;
      delay_timer <= '0;
    end else if (move) begin
      st <= st_next;
      delay_timer <= delay_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      scl_a <= st_next.pins[0];
      sda_a <= st_next.pins[1];
      sda_a_drive_enable <= st_next.pins[2];
      scl_b <= st_next.pins[3];
      sda_b <= st_next.pins[4];
      sda_b_drive_enable <= st_next.pins[5];
      busy_res <= (st_next.phase != PH_IDLE);
      done_res <= step_done;
      rx_byte <= st_next.last_rx;
      ack_failed <= st_next.fail_flag;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done result reports busy");

  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid && (busy_res == (st.phase != PH_IDLE)))
    else $error("busy result disagrees with sequencer phase");

  a_pins_hold_mid_phase: assert property (@(posedge clk) disable iff (rst)
    move && st.phase != PH_IDLE && st.phase != PH_WA_POLL && delay_timer > TIMER_BITS'(1)
    |=> $stable(st.pins))
    else $error("pin levels changed before the half period ran out");

endmodule
